/* sv/v3pu_pkg.sv */
`timescale 1ns / 1ps

package v3pu_pkg;

    localparam int unsigned COMP_W = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned MAG_W  = 31;
    localparam int unsigned SQ_W   = 2 * MAG_W;
    localparam int unsigned SUM_W  = 64;
    localparam int unsigned ROOT_W = 32;
    localparam int unsigned QUO_W  = 17;
    localparam int unsigned UNIT_W = QUO_W + 1;
    localparam int unsigned NUM_W  = MAG_W + FRAC_W + 1;
    localparam int unsigned ST_W   = 2;

    localparam logic [ST_W-1:0] ST_PASS     = 2'd0;
    localparam logic [ST_W-1:0] ST_PROJ     = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_REM = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO_TGT = 2'd3;

    localparam logic signed [COMP_W-1:0] Q_ONE = 32'sd65536;

endpackage

/* sv/vec3_perpendicular_unit.sv */
`timescale 1ns / 1ps
// channel | bus   | tdata (low bit up)                                  | tuser
// s_*     | in    | target_x, target_y, target_z, orient_x/y/z (32 ea) | bypass, basis_at_origin
// m_*     | out   | result_x, result_y, result_z (32 ea)               | status
//
// One request per cycle while s_tready is high.
// The datapath contains two unit-length scalers, each a 32-stage square root
// and a 17-stage restoring divider, one root or quotient bit per stage.
// rst_n clears all valid bits; datapath registers are not reset.
// The whole pipeline holds while m_tvalid is high and m_tready is low.

module vec3_perpendicular_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // target_x, target_y, target_z, orient_x, orient_y, orient_z
    input  logic [1:0]   s_tuser,   // bypass, basis_at_origin
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // result_x, result_y, result_z
    output logic [1:0]   m_tuser    // status
);

    localparam int CW    = v3pu_pkg::COMP_W;
    localparam int MW    = v3pu_pkg::MAG_W;
    localparam int UW    = v3pu_pkg::UNIT_W;
    localparam int SW    = v3pu_pkg::ST_W;
    localparam int PROD_W = CW + UW;
    localparam int DOT_W  = PROD_W + 2;
    localparam int D16_W  = DOT_W - v3pu_pkg::FRAC_W + 1;
    localparam int PR_W   = UW + D16_W;
    localparam int RES_W  = 40;
    localparam int RND_W  = 56;
    localparam int SH_W   = 4;
    localparam int SB_W   = 3 * CW + SW;

    function automatic logic [RND_W-1:0] rnd_shr16(input logic [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        mag = v[RND_W-1] ? (RND_W'(0) - v) : v;
        mag = (mag + (RND_W'(1) << (v3pu_pkg::FRAC_W - 1))) >> v3pu_pkg::FRAC_W;
        return v[RND_W-1] ? (RND_W'(0) - mag) : mag;
    endfunction

    logic en;

    logic                   vld_a_reg;
    logic [2:0][CW-1:0]     tmag_a_reg;
    logic [2:0]             tneg_a_reg;
    logic [2:0][CW-1:0]     o_a_reg;
    logic [SW-1:0]          st_a_reg;
    logic [2:0][CW-1:0]     tmag_next;
    logic [SW-1:0]          st_next;
    logic [2:0][MW-1:0]     n1_mag;

    logic                   n1_vld;
    logic [2:0][UW-1:0]     n1_unit;
    logic [SB_W-1:0]        n1_sb;

    logic                   vld_c_reg, vld_d_reg, vld_e_reg, vld_f_reg, vld_g_reg, vld_h_reg;
    logic [2:0][PROD_W-1:0] prod_c_reg;
    logic [2:0][UW-1:0]     u_c_reg, u_d_reg, u_e_reg;
    logic [2:0][CW-1:0]     o_c_reg, o_d_reg, o_e_reg, o_f_reg, o_g_reg, o_h_reg;
    logic [SW-1:0]          st_c_reg, st_d_reg, st_e_reg, st_f_reg, st_g_reg, st_h_reg;
    logic [DOT_W-1:0]       p_d_reg;
    logic [D16_W-1:0]       p16_e_reg;
    logic [2:0][PR_W-1:0]   pr_f_reg;
    logic [2:0][RES_W-1:0]  r_g_reg;
    logic [2:0][RES_W-1:0]  r_next;
    logic [2:0][MW-1:0]     mag_h_reg;
    logic [2:0]             neg_h_reg;
    logic [2:0][MW-1:0]     mag_h_next;
    logic [SW-1:0]          st_h_next;
    logic [RND_W-1:0]       p16_full;

    logic                   n2_vld;
    logic [2:0][UW-1:0]     n2_unit;
    logic [SB_W-1:0]        n2_sb;
    logic [2:0][CW-1:0]     n2_o;
    logic [SW-1:0]          n2_st;

    logic                   m_vld_reg;
    logic [95:0]            m_data_reg;
    logic [SW-1:0]          m_user_reg;
    logic [95:0]            m_data_next;

    assign en       = !m_vld_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            tmag_next[j] = s_tdata[j*CW + CW-1] ? (CW'(0) - s_tdata[j*CW +: CW])
                                                : s_tdata[j*CW +: CW];
        if (s_tuser[0] || s_tuser[1])
            st_next = v3pu_pkg::ST_PASS;
        else if (s_tdata[3*CW-1:0] == '0)
            st_next = v3pu_pkg::ST_ZERO_TGT;
        else
            st_next = v3pu_pkg::ST_PROJ;
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            n1_mag[j] = (tmag_a_reg[0][CW-1] || tmag_a_reg[1][CW-1] || tmag_a_reg[2][CW-1])
                      ? tmag_a_reg[j][CW-1:1] : tmag_a_reg[j][MW-1:0];
    end

    v3pu_norm #(
        .SB_W (SB_W)
    ) u_norm_tgt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_a_reg),
        .in_mag   (n1_mag),
        .in_neg   (tneg_a_reg),
        .in_sb    ({st_a_reg, o_a_reg}),
        .out_vld  (n1_vld),
        .out_unit (n1_unit),
        .out_sb   (n1_sb)
    );

    assign p16_full = rnd_shr16(RND_W'($signed(p_d_reg)));

    always_comb
    begin
        logic [RND_W-1:0] rp;
        logic [RES_W-1:0] mag;
        logic [RES_W-1:0] all_or;
        logic [SH_W-1:0]  sh;
        for (int j = 0; j < 3; j++)
        begin
            rp = rnd_shr16(RND_W'($signed(pr_f_reg[j])));
            r_next[j] = RES_W'($signed(o_f_reg[j])) - rp[RES_W-1:0];
        end
        all_or = '0;
        for (int j = 0; j < 3; j++)
        begin
            mag = r_g_reg[j][RES_W-1] ? (RES_W'(0) - r_g_reg[j]) : r_g_reg[j];
            all_or = all_or | mag;
        end
        sh = '0;
        for (int k = 0; k < RES_W - MW; k++)
            if (all_or[MW + k])
                sh = SH_W'(k + 1);
        for (int j = 0; j < 3; j++)
        begin
            mag = r_g_reg[j][RES_W-1] ? (RES_W'(0) - r_g_reg[j]) : r_g_reg[j];
            mag = mag >> sh;
            mag_h_next[j] = mag[MW-1:0];
        end
        if (st_g_reg == v3pu_pkg::ST_PROJ && r_g_reg == '0)
            st_h_next = v3pu_pkg::ST_ZERO_REM;
        else
            st_h_next = st_g_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            vld_h_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= s_tvalid;
            vld_c_reg <= n1_vld;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
            vld_h_reg <= vld_g_reg;
            m_vld_reg <= n2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tmag_a_reg <= tmag_next;
            for (int j = 0; j < 3; j++)
                tneg_a_reg[j] <= s_tdata[j*CW + CW-1];
            o_a_reg  <= s_tdata[6*CW-1:3*CW];
            st_a_reg <= st_next;

            {st_c_reg, o_c_reg} <= n1_sb;
            u_c_reg <= n1_unit;
            for (int j = 0; j < 3; j++)
                prod_c_reg[j] <= PROD_W'($signed(n1_sb[j*CW +: CW]))
                               * PROD_W'($signed(n1_unit[j]));

            p_d_reg <= DOT_W'($signed(prod_c_reg[0])) + DOT_W'($signed(prod_c_reg[1]))
                     + DOT_W'($signed(prod_c_reg[2]));
            u_d_reg  <= u_c_reg;
            o_d_reg  <= o_c_reg;
            st_d_reg <= st_c_reg;

            p16_e_reg <= p16_full[D16_W-1:0];
            u_e_reg   <= u_d_reg;
            o_e_reg   <= o_d_reg;
            st_e_reg  <= st_d_reg;

            for (int j = 0; j < 3; j++)
                pr_f_reg[j] <= PR_W'($signed(u_e_reg[j])) * PR_W'($signed(p16_e_reg));
            o_f_reg  <= o_e_reg;
            st_f_reg <= st_e_reg;

            r_g_reg  <= r_next;
            o_g_reg  <= o_f_reg;
            st_g_reg <= st_f_reg;

            mag_h_reg <= mag_h_next;
            for (int j = 0; j < 3; j++)
                neg_h_reg[j] <= r_g_reg[j][RES_W-1];
            o_h_reg  <= o_g_reg;
            st_h_reg <= st_h_next;

            m_data_reg <= m_data_next;
            m_user_reg <= n2_st;
        end
    end

    v3pu_norm #(
        .SB_W (SB_W)
    ) u_norm_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_h_reg),
        .in_mag   (mag_h_reg),
        .in_neg   (neg_h_reg),
        .in_sb    ({st_h_reg, o_h_reg}),
        .out_vld  (n2_vld),
        .out_unit (n2_unit),
        .out_sb   (n2_sb)
    );

    assign {n2_st, n2_o} = n2_sb;

    always_comb
    begin
        case (n2_st)
            v3pu_pkg::ST_PROJ:
            begin
                for (int j = 0; j < 3; j++)
                    m_data_next[j*CW +: CW] = CW'($signed(n2_unit[j]));
            end
            v3pu_pkg::ST_ZERO_REM:
                m_data_next = '0;
            default:
                m_data_next = n2_o;
        endcase
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_zero_rem_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == v3pu_pkg::ST_ZERO_REM |-> m_tdata == '0)
        else $error("zero remainder result not zero");

    a_proj_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == v3pu_pkg::ST_PROJ |-> m_tdata != '0)
        else $error("normalized result is zero");

    a_proj_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == v3pu_pkg::ST_PROJ |->
        $signed(m_tdata[31:0]) <= v3pu_pkg::Q_ONE && $signed(m_tdata[31:0]) >= -v3pu_pkg::Q_ONE
        && $signed(m_tdata[63:32]) <= v3pu_pkg::Q_ONE
        && $signed(m_tdata[63:32]) >= -v3pu_pkg::Q_ONE
        && $signed(m_tdata[95:64]) <= v3pu_pkg::Q_ONE
        && $signed(m_tdata[95:64]) >= -v3pu_pkg::Q_ONE)
        else $error("normalized component beyond 1.0");

endmodule

/* sv/v3pu_isqrt.sv */
`timescale 1ns / 1ps

module v3pu_isqrt #(
    parameter int SB_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [v3pu_pkg::SUM_W-1:0]   in_val,
    input  logic [SB_W-1:0]              in_sb,
    output logic                         out_vld,
    output logic [v3pu_pkg::ROOT_W-1:0]  out_root,
    output logic [SB_W-1:0]              out_sb
);

    localparam int STEPS = v3pu_pkg::ROOT_W;
    localparam int W     = v3pu_pkg::SUM_W;

    logic            vld_reg  [STEPS];
    logic [W-1:0]    rem_reg  [STEPS];
    logic [W-1:0]    root_reg [STEPS];
    logic [SB_W-1:0] sb_reg   [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);

            logic            v_prev;
            logic [W-1:0]    rem_prev;
            logic [W-1:0]    root_prev;
            logic [SB_W-1:0] sb_prev;
            logic [W-1:0]    trial;
            logic [W-1:0]    rem_next;
            logic [W-1:0]    root_next;

            if (k == 0)
            begin : g_first
                assign v_prev    = in_vld;
                assign rem_prev  = in_val;
                assign root_prev = '0;
                assign sb_prev   = in_sb;
            end
            else
            begin : g_later
                assign v_prev    = vld_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign sb_prev   = sb_reg[k-1];
            end

            assign trial = root_prev + BIT;

            always_comb
            begin
                if (rem_prev >= trial)
                begin
                    rem_next  = rem_prev - trial;
                    root_next = (root_prev >> 1) + BIT;
                end
                else
                begin
                    rem_next  = rem_prev;
                    root_next = root_prev >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    sb_reg[k]   <= sb_prev;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STEPS-1];
    assign out_root = root_reg[STEPS-1][v3pu_pkg::ROOT_W-1:0];
    assign out_sb   = sb_reg[STEPS-1];

endmodule

/* sv/v3pu_div.sv */
`timescale 1ns / 1ps

module v3pu_div #(
    parameter int SB_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [2:0][v3pu_pkg::NUM_W-1:0]     in_num,
    input  logic [v3pu_pkg::ROOT_W-1:0]         in_den,
    input  logic [SB_W-1:0]                     in_sb,
    output logic                                out_vld,
    output logic [2:0][v3pu_pkg::QUO_W-1:0]     out_quo,
    output logic [SB_W-1:0]                     out_sb
);

    localparam int QW = v3pu_pkg::QUO_W;
    localparam int DW = v3pu_pkg::ROOT_W;
    localparam int NW = v3pu_pkg::NUM_W;

    // quotient is known to fit QW bits, so the top NW-QW bits start below den
    logic                  vld_reg [QW];
    logic [2:0][DW-1:0]    rem_reg [QW];
    logic [2:0][QW-1:0]    low_reg [QW];
    logic [2:0][QW-1:0]    quo_reg [QW];
    logic [DW-1:0]         den_reg [QW];
    logic [SB_W-1:0]       sb_reg  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic               v_prev;
            logic [2:0][DW-1:0] rem_prev;
            logic [2:0][QW-1:0] low_prev;
            logic [2:0][QW-1:0] quo_prev;
            logic [DW-1:0]      den_prev;
            logic [SB_W-1:0]    sb_prev;
            logic [2:0][DW-1:0] rem_next;
            logic [2:0][QW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        rem_prev[j] = DW'(in_num[j][NW-1:QW]);
                        low_prev[j] = in_num[j][QW-1:0];
                    end
                end
                assign v_prev   = in_vld;
                assign quo_prev = '0;
                assign den_prev = in_den;
                assign sb_prev  = in_sb;
            end
            else
            begin : g_later
                assign v_prev   = vld_reg[k-1];
                assign rem_prev = rem_reg[k-1];
                assign low_prev = low_reg[k-1];
                assign quo_prev = quo_reg[k-1];
                assign den_prev = den_reg[k-1];
                assign sb_prev  = sb_reg[k-1];
            end

            always_comb
            begin
                logic [DW:0] cat;
                for (int j = 0; j < 3; j++)
                begin
                    cat = {rem_prev[j], low_prev[j][QW-1-k]};
                    if (cat >= {1'b0, den_prev})
                    begin
                        rem_next[j] = DW'(cat - {1'b0, den_prev});
                        quo_next[j] = {quo_prev[j][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[j] = cat[DW-1:0];
                        quo_next[j] = {quo_prev[j][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_prev;
                    quo_reg[k] <= quo_next;
                    den_reg[k] <= den_prev;
                    sb_reg[k]  <= sb_prev;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[QW-1];
    assign out_quo = quo_reg[QW-1];
    assign out_sb  = sb_reg[QW-1];

endmodule

/* sv/v3pu_norm.sv */
`timescale 1ns / 1ps

module v3pu_norm #(
    parameter int SB_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [2:0][v3pu_pkg::MAG_W-1:0]     in_mag,
    input  logic [2:0]                          in_neg,
    input  logic [SB_W-1:0]                     in_sb,
    output logic                                out_vld,
    output logic [2:0][v3pu_pkg::UNIT_W-1:0]    out_unit,
    output logic [SB_W-1:0]                     out_sb
);

    localparam int MW   = v3pu_pkg::MAG_W;
    localparam int ISB_W = 3 * MW + 3 + SB_W;
    localparam int DSB_W = 3 + SB_W;

    logic                                   sq_vld_reg;
    logic [2:0][v3pu_pkg::SQ_W-1:0]         sq_reg;
    logic [2:0][MW-1:0]                     sq_mag_reg;
    logic [2:0]                             sq_neg_reg;
    logic [SB_W-1:0]                        sq_sb_reg;

    logic                                   sum_vld_reg;
    logic [v3pu_pkg::SUM_W-1:0]             sum_reg;
    logic [2:0][MW-1:0]                     sum_mag_reg;
    logic [2:0]                             sum_neg_reg;
    logic [SB_W-1:0]                        sum_sb_reg;

    logic                                   rt_vld;
    logic [v3pu_pkg::ROOT_W-1:0]            rt_root;
    logic [ISB_W-1:0]                       rt_sb;
    logic [2:0][MW-1:0]                     rt_mag;
    logic [2:0]                             rt_neg;
    logic [SB_W-1:0]                        rt_user;
    logic [v3pu_pkg::ROOT_W-1:0]            rt_den;

    logic                                   pre_vld_reg;
    logic [2:0][v3pu_pkg::NUM_W-1:0]        pre_num_reg;
    logic [v3pu_pkg::ROOT_W-1:0]            pre_den_reg;
    logic [2:0]                             pre_neg_reg;
    logic [SB_W-1:0]                        pre_sb_reg;

    logic                                   dv_vld;
    logic [2:0][v3pu_pkg::QUO_W-1:0]        dv_quo;
    logic [DSB_W-1:0]                       dv_sb;

    logic                                   out_vld_reg;
    logic [2:0][v3pu_pkg::UNIT_W-1:0]       out_unit_reg;
    logic [SB_W-1:0]                        out_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            pre_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg  <= in_vld;
            sum_vld_reg <= sq_vld_reg;
            pre_vld_reg <= rt_vld;
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                sq_reg[j] <= v3pu_pkg::SQ_W'(in_mag[j]) * v3pu_pkg::SQ_W'(in_mag[j]);
            sq_mag_reg <= in_mag;
            sq_neg_reg <= in_neg;
            sq_sb_reg  <= in_sb;

            sum_reg <= v3pu_pkg::SUM_W'(sq_reg[0]) + v3pu_pkg::SUM_W'(sq_reg[1])
                     + v3pu_pkg::SUM_W'(sq_reg[2]);
            sum_mag_reg <= sq_mag_reg;
            sum_neg_reg <= sq_neg_reg;
            sum_sb_reg  <= sq_sb_reg;
        end
    end

    v3pu_isqrt #(
        .SB_W (ISB_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sum_vld_reg),
        .in_val   (sum_reg),
        .in_sb    ({sum_sb_reg, sum_neg_reg, sum_mag_reg}),
        .out_vld  (rt_vld),
        .out_root (rt_root),
        .out_sb   (rt_sb)
    );

    assign {rt_user, rt_neg, rt_mag} = rt_sb;
    assign rt_den = (rt_root == '0) ? v3pu_pkg::ROOT_W'(1) : rt_root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                pre_num_reg[j] <= v3pu_pkg::NUM_W'({rt_mag[j], v3pu_pkg::FRAC_W'(0)})
                                + v3pu_pkg::NUM_W'(rt_den >> 1);
            pre_den_reg <= rt_den;
            pre_neg_reg <= rt_neg;
            pre_sb_reg  <= rt_user;
        end
    end

    v3pu_div #(
        .SB_W (DSB_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pre_vld_reg),
        .in_num  (pre_num_reg),
        .in_den  (pre_den_reg),
        .in_sb   ({pre_sb_reg, pre_neg_reg}),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_sb  (dv_sb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                out_unit_reg[j] <= dv_sb[j] ? (v3pu_pkg::UNIT_W'(0) - v3pu_pkg::UNIT_W'(dv_quo[j]))
                                            : v3pu_pkg::UNIT_W'(dv_quo[j]);
            out_sb_reg <= dv_sb[DSB_W-1:3];
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_unit = out_unit_reg;
    assign out_sb   = out_sb_reg;

endmodule

/* tb/sv/tb_vec3_perpendicular_unit.sv */
`timescale 1ns / 1ps

module tb_vec3_perpendicular_unit;

    localparam int N_RAND     = 1150;
    localparam int LATENCY    = 114;
    localparam int CYCLE_LIM  = 400000;

    typedef struct packed {
        logic signed [31:0] tx, ty, tz, ox, oy, oz;
        logic               bypass, at_origin;
    } vec_req_t;

    typedef struct packed {
        logic signed [31:0]        rx, ry, rz;
        logic [v3pu_pkg::ST_W-1:0] st;
    } vec_res_t;

    typedef struct {
        vec_req_t req;
        bit       has_exp;
        vec_res_t exp;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    vec3_perpendicular_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    vec_res_t   pending_results[$];
    int         n_err;
    int         n_sent;
    int         n_recv;
    int         cnt_status[4];
    int         cycles;
    bit         calm;
    dir_row_t   dir_rows[$];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint round_sh16(longint v);
        logic [63:0] mag;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag + 64'd32768) >> 16;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic to_unit(input longint v[3], output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] q;
        for (int i = 0; i < 3; i++)
            m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
        while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
        begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root64(s);
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 16) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    task automatic predict_item(input vec_req_t r, output vec_res_t y);
        longint t[3];
        longint o[3];
        longint u[3];
        longint rem[3];
        longint res[3];
        longint p;
        t = '{r.tx, r.ty, r.tz};
        o = '{r.ox, r.oy, r.oz};
        res = o;
        if (r.bypass || r.at_origin)
            y.st = v3pu_pkg::ST_PASS;
        else if (t[0] == 0 && t[1] == 0 && t[2] == 0)
            y.st = v3pu_pkg::ST_ZERO_TGT;
        else
        begin
            to_unit(t, u);
            p = round_sh16(o[0] * u[0] + o[1] * u[1] + o[2] * u[2]);
            for (int i = 0; i < 3; i++)
                rem[i] = o[i] - round_sh16(u[i] * p);
            if (rem[0] == 0 && rem[1] == 0 && rem[2] == 0)
            begin
                y.st = v3pu_pkg::ST_ZERO_REM;
                res = '{0, 0, 0};
            end
            else
            begin
                y.st = v3pu_pkg::ST_PROJ;
                to_unit(rem, res);
            end
        end
        y.rx = res[0][31:0];
        y.ry = res[1][31:0];
        y.rz = res[2][31:0];
    endtask

    function automatic logic [31:0] rnd_comp();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            4: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input vec_req_t r, input bit has_exp, input vec_res_t exp);
        vec_res_t y;
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.oz, r.oy, r.ox, r.tz, r.ty, r.tx};
        s_tuser  <= {r.at_origin, r.bypass};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(r, y);
        if (has_exp && y != exp)
        begin
            n_err++;
            if (n_err <= 10)
                $display("directed row %0d: table %p model %p", n_sent, exp, y);
        end
        pending_results.push_back(has_exp ? exp : y);
        n_sent++;
    endtask

    function automatic vec_req_t mk(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                    logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                    bit bp, bit org);
        vec_req_t r;
        r = '{tx, ty, tz, ox, oy, oz, bp, org};
        return r;
    endfunction

    task automatic add_row(input vec_req_t r, input bit has_exp, input vec_res_t exp);
        dir_row_t d;
        d.req = r;
        d.has_exp = has_exp;
        d.exp = exp;
        dir_rows.push_back(d);
    endtask

    // result checker
    always @(posedge clk)
    begin
        vec_res_t got;
        vec_res_t exp;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
                n_recv++;
                if (pending_results.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    exp = pending_results.pop_front();
                    cnt_status[exp.st]++;
                    if (got != exp)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch #%0d: exp x=%h y=%h z=%h st=%0d",
                                      " got x=%h y=%h z=%h st=%0d"},
                                     n_recv, exp.rx, exp.ry, exp.rz, exp.st,
                                     got.rx, got.ry, got.rz, got.st);
                    end
                end
            end
        end
    end

    // output backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIM)
        begin
            $display("timeout after %0d cycles, %0d requests outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        vec_req_t r;
        vec_res_t none;
        int       drain;
        none = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        n_err = 0;
        n_sent = 0;
        n_recv = 0;
        cycles = 0;
        calm = 1'b0;
        cnt_status = '{0, 0, 0, 0};

        // bypass, origin, both, zero target: output is the orientation
        add_row(mk(1, 2, 3, 32'h8000_0000, 32'h7fff_ffff, 5, 1, 0), 1,
                '{32'h8000_0000, 32'h7fff_ffff, 5, v3pu_pkg::ST_PASS});
        add_row(mk(1, 2, 3, -7, 0, 32'h7fff_ffff, 0, 1), 1,
                '{-7, 0, 32'h7fff_ffff, v3pu_pkg::ST_PASS});
        add_row(mk(0, 0, 0, 9, 8, 7, 1, 1), 1, '{9, 8, 7, v3pu_pkg::ST_PASS});
        add_row(mk(0, 0, 0, 32'hffff_ffff, 32'h8000_0000, 1, 0, 0), 1,
                '{32'hffff_ffff, 32'h8000_0000, 1, v3pu_pkg::ST_ZERO_TGT});
        // parallel orientation: zero remainder
        add_row(mk(v3pu_pkg::Q_ONE, 0, 0, 3 * v3pu_pkg::Q_ONE, 0, 0, 0, 0), 1,
                '{0, 0, 0, v3pu_pkg::ST_ZERO_REM});
        add_row(mk(0, 0, -v3pu_pkg::Q_ONE, 0, 0, v3pu_pkg::Q_ONE, 0, 0), 1,
                '{0, 0, 0, v3pu_pkg::ST_ZERO_REM});
        // orthogonal axes: unit result; then zero target and zero orientation
        add_row(mk(v3pu_pkg::Q_ONE, 0, 0, 0, 5 * v3pu_pkg::Q_ONE, 0, 0, 0), 1,
                '{0, v3pu_pkg::Q_ONE, 0, v3pu_pkg::ST_PROJ});
        add_row(mk(0, v3pu_pkg::Q_ONE, 0, 0, 0, -2, 0, 0), 1,
                '{0, 0, -v3pu_pkg::Q_ONE, v3pu_pkg::ST_PROJ});
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, v3pu_pkg::ST_ZERO_TGT});
        add_row(mk(1, 2, 3, 0, 0, 0, 0, 0), 1, '{0, 0, 0, v3pu_pkg::ST_ZERO_REM});
        // extremes, predictor-checked
        add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0), 0, none);
        add_row(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0), 0, none);
        add_row(mk(32'h7fff_ffff, 0, 1, 1, 32'h7fff_ffff, 0, 0, 0), 0, none);
        add_row(mk(1, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0), 0, none);
        add_row(mk(1, 1, 1, 1, 0, 0, 0, 0), 0, none);
        add_row(mk(32'hffff_ffff, 0, 0, 1, 1, 0, 0, 0), 0, none);
        add_row(mk(3 * v3pu_pkg::Q_ONE, 4 * v3pu_pkg::Q_ONE, 0,
                   v3pu_pkg::Q_ONE, -v3pu_pkg::Q_ONE, 2 * v3pu_pkg::Q_ONE, 0, 0), 0, none);
        add_row(mk(32'h8000_0000, 1, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   0, 0), 0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);

        for (int k = 0; k < N_RAND; k++)
        begin
            calm = (k >= 400 && k < 600);
            r = mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 19) == 0)
                {r.tx, r.ty, r.tz} = '0;
            else if ($urandom_range(0, 9) == 0)
            begin
                // orientation a multiple of the target: remainder tends to zero
                r.tx = $signed($urandom_range(0, 64)) - 32;
                r.ty = $signed($urandom_range(0, 64)) - 32;
                r.tz = $signed($urandom_range(0, 64)) - 32;
                r.ox = r.tx * 4;
                r.oy = r.ty * 4;
                r.oz = r.tz * 4;
            end
            send(r, 0, none);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < LATENCY + 20)
        begin
            @(posedge clk);
            drain++;
        end

        $display("%0d requests sent, %0d results checked in %0d cycles", n_sent, n_recv, cycles);
        $display("status mix: pass %0d, projected %0d, zero remainder %0d, zero target %0d",
                 cnt_status[0], cnt_status[1], cnt_status[2], cnt_status[3]);
        if (n_err == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d errors", n_err);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/v3pu_pkg.sv
sv/v3pu_isqrt.sv
sv/v3pu_div.sv
sv/v3pu_norm.sv
sv/vec3_perpendicular_unit.sv
tb/sv/tb_vec3_perpendicular_unit.sv
